>>> hdl/ifma_pkg.sv
package ifma_pkg;

	// table size and derived widths
	localparam int ENTRIES   = 16;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W    = 32;
	localparam int PFX_W     = 6;
	localparam int HIT_IDX_W = 4;
	localparam int STAT_W    = 2;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_LOOKUP = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPFX = 2'd2;

	// loopback entry appended on finish when the table is not empty
	localparam logic [ADDR_W-1:0] LOOPBACK_NET = 32'h7F00_0000;
	localparam logic [PFX_W-1:0]  LOOPBACK_PFX = 6'd8;
	localparam logic [PFX_W-1:0]  MAX_PFX      = 6'd32;

	typedef logic [ADDR_W-1:0] addr_t;

	// lookup token that travels down the cell row
	typedef struct packed {
		logic             valid;
		addr_t            addr;
		logic [CNT_W-1:0] left;     // live entries not yet passed
		logic [IDX_W-1:0] pos;      // index of the cell it enters
		logic             found;
		logic             rej;
		logic [IDX_W-1:0] hit_idx;
	} tok_t;

	// entry write broadcast to the row
	typedef struct packed {
		addr_t low;
		addr_t high;
		logic  rej;
	} wr_t;

endpackage

>>> hdl/ipv4_first_match_acl.sv
// Clear, add and finish: result one cycle after the item is accepted.
// Lookup: a token walks the row of ENTRIES cells, one cell a cycle; its
// result is registered after the last cell. One item in flight: input
// stalls until done; other commands every cycle unless the output stalls.
// Reset (arst_n low, asynchronous) empties the table and clears all valid
// flags; entry contents are not reset.
module ipv4_first_match_acl import ifma_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [ADDR_W-1:0]    address,
	input  logic [PFX_W-1:0]     prefix_len,
	input  logic                 reject_flag,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 blocked,
	output logic                 hit,
	output logic [HIT_IDX_W-1:0] hit_index,
	output logic [STAT_W-1:0]    status
);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              out_valid_q;
	logic              blocked_q;
	logic              hit_q;
	logic [HIT_IDX_W-1:0] hit_index_q;
	logic [STAT_W-1:0] status_q;

	logic              in_acc;
	logic              full;
	logic              do_wr;
	logic [STAT_W-1:0] cmd_status;
	logic [PFX_W-1:0]  wr_pfx;
	addr_t             wr_addr;
	addr_t             mask;
	wr_t               wr;
	logic [ENTRIES-1:0] wr_en;
	tok_t              head;
	tok_t              chain [ENTRIES+1];
	tok_t              tail;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign full     = (cnt_q >= CNT_W'(ENTRIES));

	// command decode: status and table write
	always_comb begin
		do_wr      = 1'b0;
		cmd_status = ST_OK;
		wr_addr    = address;
		wr_pfx     = prefix_len;
		wr.rej     = reject_flag;
		unique case (cmd)
			CMD_CLEAR: begin
			end
			CMD_ADD: begin
				if (prefix_len > MAX_PFX) begin
					cmd_status = ST_BADPFX;
				end else if (full) begin
					cmd_status = ST_FULL;
				end else begin
					do_wr = 1'b1;
				end
			end
			CMD_FINISH: begin
				wr_addr = LOOPBACK_NET;
				wr_pfx  = LOOPBACK_PFX;
				wr.rej  = 1'b0;
				if (cnt_q != '0) begin
					if (full) begin
						cmd_status = ST_FULL;
					end else begin
						do_wr = 1'b1;
					end
				end
			end
			CMD_LOOKUP: begin
			end
			default: begin
			end
		endcase
		mask    = ~({ADDR_W{1'b1}} >> wr_pfx);
		wr.low  = wr_addr & mask;
		wr.high = wr_addr | ~mask;
	end

	// one-hot write select: next free slot
	for (genvar i = 0; i < ENTRIES; i++) begin : g_wr
		assign wr_en[i] = in_acc && do_wr && (cnt_q == CNT_W'(i));
	end

	// token entering the first cell
	always_comb begin
		head         = '0;
		head.valid   = in_acc && (cmd == CMD_LOOKUP);
		head.addr    = address;
		head.left    = cnt_q;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ifma_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en[i]),
			.wr      (wr),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign tail = chain[ENTRIES];

	// entry count and lookup-in-flight flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (in_acc && cmd == CMD_CLEAR) begin
				cnt_q <= '0;
			end else if (in_acc && do_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (in_acc && cmd == CMD_LOOKUP) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tail.valid || (in_acc && cmd != CMD_LOOKUP)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			blocked_q   <= tail.found ? tail.rej : (cnt_q != '0);
			hit_q       <= tail.found;
			hit_index_q <= HIT_IDX_W'(tail.hit_idx);
			status_q    <= ST_OK;
		end else if (in_acc && cmd != CMD_LOOKUP) begin
			blocked_q   <= 1'b0;
			hit_q       <= 1'b0;
			hit_index_q <= '0;
			status_q    <= cmd_status;
		end
	end

	assign out_valid = out_valid_q;
	assign blocked   = blocked_q;
	assign hit       = hit_q;
	assign hit_index = hit_index_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("lookup result without lookup in flight");

	a_tail_free: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> !out_valid_q)
		else $error("lookup result while output register occupied");

	a_wr_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_en))
		else $error("more than one cell written");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == CMD_LOOKUP) |=> busy_q)
		else $error("lookup accepted but not in flight");
`endif

endmodule

>>> hdl/ifma_cell.sv
module ifma_cell import ifma_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  wr_t  wr,
	input  tok_t tok_in,
	output tok_t tok_out
);

	addr_t low_q;
	addr_t high_q;
	logic  rej_q;
	logic  valid_q;
	tok_t  tok_q;
	tok_t  nxt;
	logic  match;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			low_q  <= wr.low;
			high_q <= wr.high;
			rej_q  <= wr.rej;
		end
	end

	// compare against this entry, keep the first hit
	always_comb begin
		nxt   = tok_in;
		match = (tok_in.left != '0) && (tok_in.addr >= low_q) && (tok_in.addr <= high_q);
		if (!tok_in.found && match) begin
			nxt.found   = 1'b1;
			nxt.rej     = rej_q;
			nxt.hit_idx = tok_in.pos;
		end
		if (tok_in.left != '0) begin
			nxt.left = tok_in.left - CNT_W'(1);
		end
		nxt.pos = tok_in.pos + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

>>> dv/ifma_checker.sv
`timescale 1ns / 1ps

module ifma_checker import ifma_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [ADDR_W-1:0]    address,
	input  logic [PFX_W-1:0]     prefix_len,
	input  logic                 reject_flag,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 blocked,
	input  logic                 hit,
	input  logic [HIT_IDX_W-1:0] hit_index,
	input  logic [STAT_W-1:0]    status,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic                 blocked;
		logic                 hit;
		logic [HIT_IDX_W-1:0] hit_index;
		logic [STAT_W-1:0]    status;
	} verdict_t;

	// shadow copy of the access list
	addr_t acl_low  [ENTRIES];
	addr_t acl_high [ENTRIES];
	logic  acl_rej  [ENTRIES];
	int    acl_count;

	verdict_t verdict_q[$];
	int       errs;

	function automatic addr_t net_mask(logic [PFX_W-1:0] plen);
		addr_t ones;
		ones = '1;
		if (plen == 0)
			return '0;
		return ones << (ADDR_W - plen);
	endfunction

	// append one range; bad prefix wins over full table
	function automatic logic [STAT_W-1:0] append_range(addr_t a, logic [PFX_W-1:0] plen,
		logic rej);
		addr_t m;
		if (plen > MAX_PFX)
			return ST_BADPFX;
		if (acl_count >= ENTRIES)
			return ST_FULL;
		m = net_mask(plen);
		acl_low[acl_count]  = a & m;
		acl_high[acl_count] = a | ~m;
		acl_rej[acl_count]  = rej;
		acl_count++;
		return ST_OK;
	endfunction

	// apply one item to the shadow list and give the verdict it must produce
	function automatic verdict_t judge_item(logic [1:0] c, addr_t a, logic [PFX_W-1:0] plen,
		logic rej);
		verdict_t v;
		v = '0;
		case (c)
			CMD_CLEAR: begin
				acl_count = 0;
			end
			CMD_ADD: begin
				v.status = append_range(a, plen, rej);
			end
			CMD_FINISH: begin
				if (acl_count != 0)
					v.status = append_range(LOOPBACK_NET, LOOPBACK_PFX, 1'b0);
			end
			CMD_LOOKUP: begin
				// empty list permits, no match denies
				if (acl_count != 0) begin
					v.blocked = 1'b1;
					for (int i = 0; i < acl_count; i++) begin
						if (a >= acl_low[i] && a <= acl_high[i]) begin
							v.blocked   = acl_rej[i];
							v.hit       = 1'b1;
							v.hit_index = HIT_IDX_W'(i);
							break;
						end
					end
				end
			end
		endcase
		return v;
	endfunction

	// compare results first, then predict the newly accepted item
	always @(posedge clk or negedge arst_n) begin : monitor
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			acl_count = 0;
			verdict_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {blocked, hit, hit_index, status};
				if (verdict_q.size() == 0) begin
					errs++;
					$display("%0t: result with no item pending: blocked=%0d hit=%0d idx=%0d status=%0d",
						$time, got.blocked, got.hit, got.hit_index, got.status);
				end else begin
					want = verdict_q.pop_front();
					if (got !== want) begin
						errs++;
						$display("%0t: mismatch: expected blocked=%0d hit=%0d idx=%0d status=%0d, got blocked=%0d hit=%0d idx=%0d status=%0d",
							$time, want.blocked, want.hit, want.hit_index, want.status,
							got.blocked, got.hit, got.hit_index, got.status);
					end
				end
			end
			if (in_valid && !in_stall)
				verdict_q.push_back(judge_item(cmd, address, prefix_len, reject_flag));
			fail_count <= errs;
			pending <= verdict_q.size();
		end
	end

endmodule

>>> dv/tb_ipv4_first_match_acl.sv
`timescale 1ns / 1ps

module tb_ipv4_first_match_acl;
	import ifma_pkg::*;

	localparam int ITEM_TARGET = 1000;
	localparam int QUIET_AFTER = 850;
	localparam int WD_LIMIT    = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           cmd;
	addr_t                address;
	logic [PFX_W-1:0]     prefix_len;
	logic                 reject_flag;
	logic                 out_valid;
	logic                 out_stall;
	logic                 blocked;
	logic                 hit;
	logic [HIT_IDX_W-1:0] hit_index;
	logic [STAT_W-1:0]    status;

	int fail_count;
	int pending;
	int items_sent;
	bit quiet_tail;

	// ranges sent so far, used to aim lookups at bounds
	addr_t                net_q[$];
	logic [PFX_W-1:0]     pfx_q[$];

	ipv4_first_match_acl u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.address     (address),
		.prefix_len  (prefix_len),
		.reject_flag (reject_flag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blocked     (blocked),
		.hit         (hit),
		.hit_index   (hit_index),
		.status      (status)
	);

	ifma_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.address     (address),
		.prefix_len  (prefix_len),
		.reject_flag (reject_flag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blocked     (blocked),
		.hit         (hit),
		.hit_index   (hit_index),
		.status      (status),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: stall bursts until the quiet tail
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall = 1'b0;
			end
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	// watchdog: too long with nothing accepted on either side
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WD_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic addr_t range_mask(logic [PFX_W-1:0] plen);
		addr_t ones;
		ones = '1;
		if (plen == 0)
			return '0;
		return ones << (ADDR_W - plen);
	endfunction

	// drive one item from a falling edge; returns at the falling edge after acceptance
	task automatic send_item(logic [1:0] c, addr_t a, logic [PFX_W-1:0] plen, logic rej);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		cmd         = c;
		address     = a;
		prefix_len  = plen;
		reject_flag = rej;
		in_valid    = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		quiet_tail = (items_sent >= QUIET_AFTER);
		case (c)
			CMD_CLEAR: begin
				net_q.delete();
				pfx_q.delete();
			end
			CMD_ADD: begin
				if (plen <= MAX_PFX) begin
					net_q.push_back(a);
					pfx_q.push_back(plen);
				end
			end
			CMD_FINISH: begin
				net_q.push_back(LOOPBACK_NET);
				pfx_q.push_back(LOOPBACK_PFX);
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	// lookup address: mostly on or just past the bounds of a sent range
	function automatic addr_t pick_probe();
		int    k;
		addr_t m;
		addr_t lo;
		addr_t hi;
		if (net_q.size() == 0 || $urandom_range(0, 5) == 0)
			return $urandom();
		k  = $urandom_range(0, net_q.size() - 1);
		m  = range_mask(pfx_q[k]);
		lo = net_q[k] & m;
		hi = net_q[k] | ~m;
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2: return lo - 1;
			3: return hi + 1;
			4: return lo | ($urandom() & ~m);
			default: return LOOPBACK_NET | ($urandom() & 32'h00FF_FFFF);
		endcase
	endfunction

	function automatic logic [PFX_W-1:0] pick_prefix();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return MAX_PFX;
			2, 3: return PFX_W'($urandom_range(33, 63));
			default: return PFX_W'($urandom_range(1, 31));
		endcase
	endfunction

	// one load of the list followed by lookups, with some noise after
	task automatic run_table_session();
		int n_add;
		int n_fin;
		if ($urandom_range(0, 3) != 0)
			send_item(CMD_CLEAR, $urandom(), PFX_W'($urandom()), 1'($urandom()));
		n_add = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 10);
		repeat (n_add)
			send_item(CMD_ADD, $urandom(), pick_prefix(), 1'($urandom()));
		case ($urandom_range(0, 5))
			0: n_fin = 0;
			1: n_fin = 2;
			default: n_fin = 1;
		endcase
		repeat (n_fin)
			send_item(CMD_FINISH, $urandom(), PFX_W'($urandom()), 1'($urandom()));
		repeat ($urandom_range(2, 12))
			send_item(CMD_LOOKUP, pick_probe(), PFX_W'($urandom()), 1'($urandom()));
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3))
				send_item(2'($urandom()), $urandom(), PFX_W'($urandom()), 1'($urandom()));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		cmd         = CMD_CLEAR;
		address     = '0;
		prefix_len  = '0;
		reject_flag = 1'b0;
		items_sent  = 0;
		quiet_tail  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, bad prefix, shadowing, host routes, loopback
		send_item(CMD_CLEAR, '1, '1, 1'b1);
		send_item(CMD_LOOKUP, 32'h0102_0304, '1, 1'b1);
		send_item(CMD_FINISH, '0, '0, 1'b0);
		send_item(CMD_ADD, 32'h0A00_0000, 6'd63, 1'b1);
		send_item(CMD_ADD, 32'h0A00_00FF, 6'd8, 1'b1);
		send_item(CMD_ADD, 32'h0A01_0000, 6'd16, 1'b0);
		send_item(CMD_ADD, 32'hFFFF_FFFF, MAX_PFX, 1'b0);
		send_item(CMD_ADD, 32'h0000_0000, MAX_PFX, 1'b1);
		send_item(CMD_LOOKUP, 32'h0A01_FFFF, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'h0000_0000, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'hC0A8_0001, '0, 1'b0);
		send_item(CMD_FINISH, '1, '1, 1'b1);
		send_item(CMD_FINISH, '0, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'h7FFF_FFFF, '0, 1'b0);
		// prefix zero covers everything left
		send_item(CMD_ADD, 32'hDEAD_BEEF, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'hC0A8_0001, '0, 1'b0);
		// fill to capacity, then full-table cases
		repeat (ENTRIES - 7)
			send_item(CMD_ADD, $urandom(), 6'd24, 1'($urandom()));
		send_item(CMD_ADD, 32'h0B00_0000, 6'd8, 1'b1);
		send_item(CMD_ADD, 32'h0B00_0000, 6'd33, 1'b1);
		send_item(CMD_FINISH, '0, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'h0B00_0000, '1, 1'b1);
		send_item(CMD_CLEAR, '0, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'h0A00_0001, '0, 1'b0);

		// random sessions; the last stretch runs with no idling
		while (items_sent < ITEM_TARGET)
			run_table_session();
		in_valid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
